// File: hdl/pls_pkg.sv
`timescale 1ns / 1ps

package pls_pkg;

    localparam int DEF_SRC_WIDTH   = 160;
    localparam int DEF_TABLE_DEPTH = 64;

    localparam int COL_W    = 8;
    localparam int LINE_W   = 8;
    localparam int PIX_W    = 6;
    localparam int TIDX_W   = 6;
    localparam int COLOUR_W = 16;
    localparam int SX_W     = 9;
    localparam int SY_W     = 8;
    localparam int XW_W     = 10;
    localparam int YW_W     = 9;
    localparam int NWRITES  = 4;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 40;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam int SCREEN_W   = 320;
    localparam int SCREEN_H   = 240;
    localparam int CENTRE_Y   = 48;
    localparam int RATIO_X0   = 27;
    localparam int RATIO_XMUL = 166;
    localparam int RATIO_XDIV = 100;
    localparam int RATIO_YMUL = 5;
    localparam int RATIO_YDIV = 3;

    localparam logic CMD_PIXEL       = 1'b0;
    localparam logic CMD_TABLE_WRITE = 1'b1;

    localparam logic SCALE_CENTRED = 1'b0;
    localparam logic SCALE_RATIO   = 1'b1;

    localparam logic [CFG_ADDR_W-1:0] REG_COLOUR_MODE = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SCALE_MODE  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SHADE_0     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SHADE_1     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_SHADE_2     = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_SHADE_3     = 3'd5;

    localparam logic [COLOUR_W-1:0] SHADE_0_RESET = 16'h8F80;
    localparam logic [COLOUR_W-1:0] SHADE_1_RESET = 16'h24CC;
    localparam logic [COLOUR_W-1:0] SHADE_2_RESET = 16'h4402;
    localparam logic [COLOUR_W-1:0] SHADE_3_RESET = 16'h0A40;

    typedef struct packed {
        logic [SX_W-1:0]    x;
        logic [SY_W-1:0]    y;
        logic [NWRITES-1:0] mask;
    } map_t;

    // The table word is 5-5-5; the first step builds 5-6-5 with the outer
    // fields exchanged, the second swaps the outer fields once more.
    function automatic logic [COLOUR_W-1:0] remap_colour(input logic [COLOUR_W-1:0] a);
        logic [COLOUR_W-1:0] r;
        logic [COLOUR_W-1:0] s;
        r = ((a & 16'h001F) << 11) | ((a & 16'h03E0) << 1) | ((a & 16'h7C00) >> 10);
        s = ((r & 16'h001F) << 11) | (r & 16'h07E0) | ((r & 16'hF800) >> 11);
        return s;
    endfunction

endpackage

// File: hdl/pls_map.sv
`timescale 1ns / 1ps

module pls_map import pls_pkg::*; #(
    parameter int SRC_WIDTH = DEF_SRC_WIDTH
) (
    input  logic [COL_W-1:0]  column,
    input  logic [LINE_W-1:0] line,
    input  logic              scale_mode,
    output map_t              map
);

    localparam int COL_N  = 2 ** COL_W;
    localparam int LINE_N = 2 ** LINE_W;
    localparam int CENTRE_X0 = (SCREEN_W - SRC_WIDTH) / 2;

    logic [XW_W-1:0] ratio_x_tab [COL_N];
    logic [YW_W-1:0] ratio_y_tab [LINE_N];
    logic            ratio_frac_tab [LINE_N];

    for (genvar g = 0; g < COL_N; g++) begin : g_xtab
        assign ratio_x_tab[g] = XW_W'(RATIO_X0 + (RATIO_XMUL * g) / RATIO_XDIV);
    end

    for (genvar g = 0; g < LINE_N; g++) begin : g_ytab
        assign ratio_y_tab[g]    = YW_W'((RATIO_YMUL * g) / RATIO_YDIV);
        assign ratio_frac_tab[g] = ((g % RATIO_YDIV) != 0);
    end

    logic [XW_W-1:0] x0;
    logic [XW_W-1:0] x1;
    logic [YW_W-1:0] y0;
    logic [YW_W-1:0] y1;
    logic            in_range;
    logic            ratio;
    logic            frac;
    logic            okx0;
    logic            okx1;
    logic            oky0;
    logic            oky1;

    always_comb begin
        in_range = {2'b00, column} < XW_W'(SRC_WIDTH);
        ratio    = (scale_mode == SCALE_RATIO);
        if (ratio) begin
            x0 = ratio_x_tab[column];
            y0 = ratio_y_tab[line];
        end else begin
            x0 = XW_W'(CENTRE_X0) + {2'b00, column};
            y0 = YW_W'(CENTRE_Y) + {1'b0, line};
        end
        frac = ratio_frac_tab[line];
        x1   = x0 + XW_W'(1);
        y1   = y0 + YW_W'(1);
        okx0 = x0 < XW_W'(SCREEN_W);
        okx1 = x1 < XW_W'(SCREEN_W);
        oky0 = y0 < YW_W'(SCREEN_H);
        oky1 = y1 < YW_W'(SCREEN_H);

        map.x       = x0[SX_W-1:0];
        map.y       = y0[SY_W-1:0];
        map.mask[0] = in_range && okx0 && oky0;
        map.mask[1] = in_range && ratio && okx1 && oky0;
        map.mask[2] = in_range && ratio && frac && okx0 && oky1;
        map.mask[3] = in_range && ratio && frac && okx1 && oky1;
    end

endmodule

// File: hdl/pls_ctable.sv
`timescale 1ns / 1ps

module pls_ctable import pls_pkg::*; #(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  logic                aclk,
    input  logic                wr_en,
    input  logic [TIDX_W-1:0]   wr_idx,
    input  logic [COLOUR_W-1:0] wr_data,
    input  logic                rd_en,
    input  logic [PIX_W-1:0]    rd_pixel,
    output logic [COLOUR_W-1:0] rd_data
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int PIX_N = 2 ** PIX_W;

    logic [COLOUR_W-1:0] mem [TABLE_DEPTH];
    logic [IDX_W-1:0]    pix_mod_tab [PIX_N];
    logic [COLOUR_W-1:0] rd_data_reg;
    logic                wr_ok;

    for (genvar g = 0; g < PIX_N; g++) begin : g_modtab
        assign pix_mod_tab[g] = IDX_W'(g % TABLE_DEPTH);
    end

    assign wr_ok = wr_en && ({3'b000, wr_idx} < 9'(TABLE_DEPTH));

    always_ff @(posedge aclk) begin
        if (wr_ok) begin
            mem[IDX_W'(wr_idx)] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[pix_mod_tab[rd_pixel]];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/palette_line_scaler.sv
`timescale 1ns / 1ps
// An accepted pixel transaction loads the table read and mapping register; its first
// screen write moves on to the output register, which drives m_axis, once that is free.
// Throughput: one item per cycle in centred mode and for table writes while m_axis does
// not stall; in ratio mode a pixel gives up to four screen writes, which leave one at a
// time through the single write port at the output register.
// Reset is synchronous and active low; it restores the register defaults, the colour
// table is left as it is and holds undefined data until written.

module palette_line_scaler import pls_pkg::*; #(
    parameter int SRC_WIDTH   = DEF_SRC_WIDTH,
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // column, line, pixel, table_index, table_data
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    // cmd
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // screen_x, screen_y, colour
    output logic [M_TDATA_W-1:0]  m_axis_tdata,
    output logic                  m_axis_tlast,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic [COL_W-1:0]    in_column;
    logic [LINE_W-1:0]   in_line;
    logic [PIX_W-1:0]    in_pixel;
    logic [TIDX_W-1:0]   in_tidx;
    logic [COLOUR_W-1:0] in_tdata;
    logic                in_cmd;

    assign in_column = s_axis_tdata[7:0];
    assign in_line   = s_axis_tdata[15:8];
    assign in_pixel  = s_axis_tdata[21:16];
    assign in_tidx   = s_axis_tdata[27:22];
    assign in_tdata  = s_axis_tdata[43:28];
    assign in_cmd    = s_axis_tuser;

    logic                colour_mode_reg;
    logic                scale_mode_reg;
    logic [COLOUR_W-1:0] shade_reg [4];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            colour_mode_reg <= 1'b0;
            scale_mode_reg  <= SCALE_RATIO;
            shade_reg[0]    <= SHADE_0_RESET;
            shade_reg[1]    <= SHADE_1_RESET;
            shade_reg[2]    <= SHADE_2_RESET;
            shade_reg[3]    <= SHADE_3_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_COLOUR_MODE: colour_mode_reg <= cfg_wdata[0];
                REG_SCALE_MODE:  scale_mode_reg  <= cfg_wdata[0];
                REG_SHADE_0:     shade_reg[0]    <= cfg_wdata;
                REG_SHADE_1:     shade_reg[1]    <= cfg_wdata;
                REG_SHADE_2:     shade_reg[2]    <= cfg_wdata;
                REG_SHADE_3:     shade_reg[3]    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic                s_accept;
    map_t                map;
    logic [COLOUR_W-1:0] table_rd;

    assign s_accept = s_axis_tvalid && s_axis_tready;

    pls_map #(
        .SRC_WIDTH(SRC_WIDTH)
    ) u_map (
        .column    (in_column),
        .line      (in_line),
        .scale_mode(scale_mode_reg),
        .map       (map)
    );

    pls_ctable #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_ctable (
        .aclk    (aclk),
        .wr_en   (s_accept && (in_cmd == CMD_TABLE_WRITE)),
        .wr_idx  (in_tidx),
        .wr_data (in_tdata),
        .rd_en   (s_accept && (in_cmd == CMD_PIXEL)),
        .rd_pixel(in_pixel),
        .rd_data (table_rd)
    );

    logic [NWRITES-1:0]  s1_mask_reg;
    logic [NWRITES-1:0]  s1_mask_next;
    logic [SX_W-1:0]     s1_x_reg;
    logic [SY_W-1:0]     s1_y_reg;
    logic [COLOUR_W-1:0] s1_shade_reg;
    logic [COLOUR_W-1:0] s1_colour;

    logic                m_valid_reg;
    logic                m_valid_next;
    logic [SX_W-1:0]     m_x_reg;
    logic [SY_W-1:0]     m_y_reg;
    logic [COLOUR_W-1:0] m_colour_reg;
    logic                m_last_reg;

    logic                out_free;
    logic                emit;
    logic [1:0]          sel;
    logic [NWRITES-1:0]  rest;

    assign out_free  = !m_valid_reg || m_axis_tready;
    assign emit      = (s1_mask_reg != '0) && out_free;
    assign s1_colour = colour_mode_reg ? remap_colour(table_rd) : s1_shade_reg;

    // The writes leave in the order same row left, same row right, next row left, next row right.
    always_comb begin
        if (s1_mask_reg[0]) begin
            sel = 2'd0;
        end else if (s1_mask_reg[1]) begin
            sel = 2'd1;
        end else if (s1_mask_reg[2]) begin
            sel = 2'd2;
        end else begin
            sel = 2'd3;
        end
        rest = s1_mask_reg & ~(NWRITES'(1) << sel);
    end

    assign s_axis_tready = (s1_mask_reg == '0) || (emit && (rest == '0));

    always_comb begin
        if (s_accept) begin
            s1_mask_next = (in_cmd == CMD_PIXEL) ? map.mask : '0;
        end else if (emit) begin
            s1_mask_next = rest;
        end else begin
            s1_mask_next = s1_mask_reg;
        end

        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_mask_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            s1_mask_reg <= s1_mask_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && (in_cmd == CMD_PIXEL)) begin
            s1_x_reg     <= map.x;
            s1_y_reg     <= map.y;
            s1_shade_reg <= shade_reg[in_pixel[1:0]];
        end
        if (emit) begin
            m_x_reg      <= s1_x_reg + SX_W'(sel[0]);
            m_y_reg      <= s1_y_reg + SY_W'(sel[1]);
            m_colour_reg <= s1_colour;
            m_last_reg   <= (rest == '0);
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tdata  = {7'b0, m_colour_reg, m_y_reg, m_x_reg};

endmodule

// File: hdl/pls_checker.sv
`timescale 1ns / 1ps

module pls_checker import pls_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [M_TDATA_W-1:0]  m_axis_tdata,
    input logic                  m_axis_tlast
);

    a_reset_clears_output: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("Output valid right after reset.");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("Stalled output transaction changed.");

    a_on_screen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[8:0] < 9'd320) && (m_axis_tdata[16:9] < 8'd240))
        else $error("Screen write outside the visible area.");

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid || m_axis_tlast)
        else $error("New transaction accepted before the previous pixel finished.");

    a_busy_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready && !m_axis_tlast |-> !s_axis_tready)
        else $error("Input ready while a pixel still has writes pending.");

endmodule

bind palette_line_scaler pls_checker u_pls_checker (.*);

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import pls_pkg::*;

    localparam int LINE_LAST   = 143;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic                cmd;
        logic [COL_W-1:0]    column;
        logic [LINE_W-1:0]   line;
        logic [PIX_W-1:0]    pixel;
        logic [TIDX_W-1:0]   tidx;
        logic [COLOUR_W-1:0] tdata;
    } src_item_t;

    typedef struct packed {
        logic [SX_W-1:0]     x;
        logic [SY_W-1:0]     y;
        logic [COLOUR_W-1:0] colour;
        logic                last;
    } screen_write_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    logic                  colour_mode_r;
    logic                  scale_mode_r;
    logic [COLOUR_W-1:0]   shade_r [4];
    logic [COLOUR_W-1:0]   pal_table [DEF_TABLE_DEPTH];
    bit                    pal_written [DEF_TABLE_DEPTH];
    int                    filled_idx [$];
    screen_write_t         pending_writes [$];

    int send_idle_pct;
    int recv_stall_pct;
    int err_count;
    int items_sent;
    int writes_checked;
    int table_writes;
    int silent_items;
    int cycle_count;

    palette_line_scaler i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d screen writes outstanding", $time,
                     pending_writes.size());
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // A 5-5-5 table word becomes 5-6-5 with a zero low green bit; the outer fields
    // end up where they started.
    function automatic logic [COLOUR_W-1:0] table_to_rgb565(input logic [COLOUR_W-1:0] w);
        return {w[14:10], w[9:5], 1'b0, w[4:0]};
    endfunction

    function automatic logic [COLOUR_W-1:0] pick_colour();
        case ($urandom_range(3))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic src_item_t pixel_item(input int col, input int row, input int pix);
        src_item_t it;
        it = '0;
        it.cmd = CMD_PIXEL;
        it.column = col[COL_W-1:0];
        it.line = row[LINE_W-1:0];
        it.pixel = pix[PIX_W-1:0];
        return it;
    endfunction

    function automatic src_item_t table_item(input int idx, input logic [COLOUR_W-1:0] word);
        src_item_t it;
        it = '0;
        it.cmd = CMD_TABLE_WRITE;
        it.tidx = idx[TIDX_W-1:0];
        it.tdata = word;
        return it;
    endfunction

    task automatic push_write(input int x, input int y, input logic [COLOUR_W-1:0] c);
        screen_write_t w;
        if (x >= SCREEN_W || y >= SCREEN_H) return;
        w.x = x[SX_W-1:0];
        w.y = y[SY_W-1:0];
        w.colour = c;
        w.last = 1'b0;
        pending_writes.push_back(w);
    endtask

    task automatic predict_writes(input src_item_t it);
        logic [COLOUR_W-1:0] c;
        screen_write_t       w;
        int                  col;
        int                  row;
        int                  x0;
        int                  y0;
        int                  n0;
        if (it.cmd == CMD_TABLE_WRITE) begin
            pal_table[it.tidx] = it.tdata;
            if (!pal_written[it.tidx]) begin
                pal_written[it.tidx] = 1'b1;
                filled_idx.push_back(int'(it.tidx));
            end
            table_writes++;
            return;
        end
        col = int'(it.column);
        row = int'(it.line);
        n0 = pending_writes.size();
        if (col < DEF_SRC_WIDTH) begin
            c = colour_mode_r ? table_to_rgb565(pal_table[it.pixel]) : shade_r[it.pixel[1:0]];
            if (scale_mode_r == SCALE_CENTRED) begin
                push_write((SCREEN_W - DEF_SRC_WIDTH) / 2 + col, CENTRE_Y + row, c);
            end else begin
                x0 = RATIO_X0 + (RATIO_XMUL * col) / RATIO_XDIV;
                y0 = (RATIO_YMUL * row) / RATIO_YDIV;
                push_write(x0, y0, c);
                push_write(x0 + 1, y0, c);
                if (row % RATIO_YDIV != 0) begin
                    push_write(x0, y0 + 1, c);
                    push_write(x0 + 1, y0 + 1, c);
                end
            end
        end
        if (pending_writes.size() > n0) begin
            w = pending_writes.pop_back();
            w.last = 1'b1;
            pending_writes.push_back(w);
        end else begin
            silent_items++;
        end
    endtask

    task automatic send_item(input src_item_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= it.cmd;
        s_axis_tdata <= {4'b0, it.tdata, it.tidx, it.pixel, it.line, it.column};
        do @(posedge aclk); while (!s_axis_tready);
        items_sent++;
        predict_writes(it);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_writes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_COLOUR_MODE: colour_mode_r = val[0];
            REG_SCALE_MODE:  scale_mode_r = val[0];
            REG_SHADE_0:     shade_r[0] = val;
            REG_SHADE_1:     shade_r[1] = val;
            REG_SHADE_2:     shade_r[2] = val;
            REG_SHADE_3:     shade_r[3] = val;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        screen_write_t got;
        screen_write_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.x = m_axis_tdata[8:0];
            got.y = m_axis_tdata[16:9];
            got.colour = m_axis_tdata[32:17];
            got.last = m_axis_tlast;
            if (pending_writes.size() == 0) begin
                err_count++;
                $display("%0t: unexpected transaction x=%0d y=%0d colour=%h last=%b",
                         $time, got.x, got.y, got.colour, got.last);
            end else begin
                want = pending_writes.pop_front();
                writes_checked++;
                if (got !== want) begin
                    err_count++;
                    $display("%0t: mismatch expected x=%0d y=%0d colour=%h last=%b",
                             $time, want.x, want.y, want.colour, want.last);
                    $display("%0t:          actual   x=%0d y=%0d colour=%h last=%b",
                             $time, got.x, got.y, got.colour, got.last);
                end
            end
        end
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic test_shade_ratio();
        send_item(pixel_item(0, 0, 0));
        send_item(pixel_item(159, LINE_LAST, 3));
        send_item(pixel_item(80, 1, 62));
        send_item(pixel_item(1, 2, 1));
        send_item(pixel_item(3, 3, 2));
        send_item(pixel_item(DEF_SRC_WIDTH, 0, 0));
        send_item(pixel_item(255, 255, 63));
        send_item(pixel_item(10, LINE_LAST + 1, 1));
        send_item(pixel_item(10, 255, 63));
        wait_drained();
    endtask

    task automatic test_centred_shades();
        write_reg(REG_SCALE_MODE, CFG_DATA_W'(SCALE_CENTRED));
        write_reg(REG_SHADE_0, 16'h0000);
        write_reg(REG_SHADE_1, 16'hFFFF);
        write_reg(REG_SHADE_2, 16'h5555);
        write_reg(REG_SHADE_3, 16'hAAAA);
        send_item(pixel_item(0, 0, 0));
        send_item(pixel_item(159, LINE_LAST, 1));
        send_item(pixel_item(0, 191, 2));
        send_item(pixel_item(5, 192, 3));
        send_item(pixel_item(255, 255, 0));
        wait_drained();
    endtask

    task automatic test_colour_table();
        write_reg(REG_COLOUR_MODE, 16'd1);
        write_reg(REG_SCALE_MODE, CFG_DATA_W'(SCALE_RATIO));
        send_item(table_item(0, 16'hFFFF));
        send_item(table_item(63, 16'h0000));
        send_item(table_item(42, 16'h8001));
        send_item(pixel_item(159, LINE_LAST, 0));
        send_item(pixel_item(0, 0, 63));
        send_item(table_item(42, 16'h7C1F));
        send_item(pixel_item(20, 7, 42));
        wait_drained();
        write_reg(REG_SCALE_MODE, CFG_DATA_W'(SCALE_CENTRED));
        send_item(pixel_item(0, 0, 42));
        send_item(table_item(21, 16'h03E0));
        send_item(pixel_item(7, 255, 21));
        send_item(pixel_item(7, 100, 21));
        wait_drained();
    endtask

    task automatic send_random_items(input int count);
        src_item_t   it;
        int unsigned roll;
        repeat (count) begin
            roll = $urandom_range(99);
            it.cmd = (roll < 20) ? CMD_TABLE_WRITE : CMD_PIXEL;
            if (roll >= 20 && roll < 32) begin
                it.column = COL_W'($urandom_range(255));
                it.line = LINE_W'($urandom_range(255));
            end else begin
                it.column = COL_W'($urandom_range(DEF_SRC_WIDTH - 1));
                it.line = LINE_W'($urandom_range(LINE_LAST));
            end
            if (colour_mode_r)
                it.pixel = PIX_W'(filled_idx[$urandom_range(filled_idx.size() - 1)]);
            else
                it.pixel = PIX_W'($urandom_range(63));
            it.tidx = TIDX_W'($urandom_range(63));
            it.tdata = COLOUR_W'($urandom);
            send_item(it);
        end
    endtask

    task automatic test_random_traffic();
        int idle_pct [4];
        int stall_pct [4];
        idle_pct = '{0, 60, 0, 13};
        stall_pct = '{0, 0, 60, 13};
        for (int seg = 0; seg < 8; seg++) begin
            send_idle_pct = idle_pct[seg / 2];
            recv_stall_pct = stall_pct[seg / 2];
            write_reg(REG_COLOUR_MODE, 16'(seg % 2));
            write_reg(REG_SCALE_MODE, 16'((seg / 2) % 2 == 0 ? 1 : 0));
            write_reg(REG_SHADE_0, pick_colour());
            write_reg(REG_SHADE_1, pick_colour());
            write_reg(REG_SHADE_2, pick_colour());
            write_reg(REG_SHADE_3, pick_colour());
            send_random_items(11);
            wait_drained();
        end
    endtask

    initial begin
        aresetn <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= 1'b0;
        m_axis_tready <= 1'b0;
        cfg_we <= 1'b0;
        cfg_addr <= '0;
        cfg_wdata <= '0;
        colour_mode_r = 1'b0;
        scale_mode_r = SCALE_RATIO;
        shade_r[0] = SHADE_0_RESET;
        shade_r[1] = SHADE_1_RESET;
        shade_r[2] = SHADE_2_RESET;
        shade_r[3] = SHADE_3_RESET;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_shade_ratio();
        test_centred_shades();
        test_colour_table();
        test_random_traffic();

        $display("Sent %0d transactions (%0d table writes, %0d without screen output).",
                 items_sent, table_writes, silent_items);
        $display("Checked %0d screen writes over both colour sources and scale modes.",
                 writes_checked);
        if (err_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

// File: sim.f
hdl/pls_pkg.sv
hdl/pls_map.sv
hdl/pls_ctable.sv
hdl/palette_line_scaler.sv
hdl/pls_checker.sv
sim/tb_top.sv
